[sv/assert_macros.svh]
// Assertion macros used by the MD5 checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/md5_pkg.sv]
// Types, constants and round tables for the MD5 digest core
package md5_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } t_md5_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_md5_out;

    // controller to datapath commands
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       len_snap;
        logic       round_start;
        logic       round_step;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       chain_init;
    } t_md5_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [5:0]  byte_pos;
        logic [63:0] len_snap;
    } t_md5_sts;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    function automatic logic [31:0] step_const(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] j);
        logic [4:0] s;
        unique case (j)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction
endpackage

[sv/md5_datapath.sv]
// MD5 datapath: block buffer, bit counter, round registers and chaining value
module md5_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md5_pkg::t_md5_cmd i_cmd,
    output md5_pkg::t_md5_sts o_sts,
    output logic [127:0]      o_chain
);
    import md5_pkg::*;

    logic [31:0] r_blk [16];
    logic [63:0] r_len, n_len, r_snap;
    logic [31:0] r_cv [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] f, t, w, rot;
    logic [3:0]  g;
    logic [5:0]  i;
    logic [4:0]  s;
    logic [5:0]  pos;

    assign pos = r_len[8:3];
    assign i = i_cmd.round_idx;
    assign w = r_blk[g];
    assign s = rot_amount({i[5:4], i[1:0]});

    always_comb begin
        unique case (i[5:4])
            2'd0: begin
                f = (r_b & r_c) | (~r_b & r_d);
                g = i[3:0];
            end
            2'd1: begin
                f = (r_d & r_b) | (~r_d & r_c);
                g = 4'(5 * i[3:0] + 1);
            end
            2'd2: begin
                f = r_b ^ r_c ^ r_d;
                g = 4'(3 * i[3:0] + 5);
            end
            default: begin
                f = r_c ^ (r_b | ~r_d);
                g = 4'(7 * i[3:0]);
            end
        endcase
        t = f + r_a + step_const(i) + w;
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
        n_len = r_len + 64'd8;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_blk[pos[5:2]][pos[1:0]*8 +: 8] <= i_cmd.push_byte;
        end
        if (i_cmd.len_snap) begin
            r_snap <= r_len;
        end
        if (i_cmd.round_start) begin
            r_a <= r_cv[0];
            r_b <= r_cv[1];
            r_c <= r_cv[2];
            r_d <= r_cv[3];
        end else if (i_cmd.round_step) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.chain_init) begin
            r_len <= '0;
            r_cv[0] <= IV_A;
            r_cv[1] <= IV_B;
            r_cv[2] <= IV_C;
            r_cv[3] <= IV_D;
        end else begin
            if (i_cmd.push) begin
                r_len <= n_len;
            end
            if (i_cmd.chain_add) begin
                r_cv[0] <= r_cv[0] + r_a;
                r_cv[1] <= r_cv[1] + r_b;
                r_cv[2] <= r_cv[2] + r_c;
                r_cv[3] <= r_cv[3] + r_d;
            end
        end
    end

    assign o_sts.byte_pos = pos;
    assign o_sts.len_snap = r_snap;
    assign o_chain = {r_cv[3], r_cv[2], r_cv[1], r_cv[0]};
endmodule

[sv/md5_ctrl.sv]
// MD5 controller: intake, padding sequence, round counter and digest output
module md5_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  md5_pkg::t_md5_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output md5_pkg::t_md5_out o_data,
    output md5_pkg::t_md5_cmd o_cmd,
    input  md5_pkg::t_md5_sts i_sts,
    input  logic [127:0]      i_chain
);
    import md5_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_ZERO = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state, r_ret, n_ret;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_widx, n_widx;
    logic       accept, full;

    assign o_stall = (r_state != S_IDLE);
    assign accept = i_valid && !o_stall;
    assign full = (i_sts.byte_pos == 6'd63);
    assign o_valid = (r_state == S_OUT);
    assign o_data.digest_word = i_chain[r_widx*32 +: 32];
    assign o_data.word_index = r_widx;
    assign o_data.last_word = (r_widx == 2'd3);

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_cnt = r_cnt;
        n_widx = r_widx;
        o_cmd = '0;
        o_cmd.round_idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.push = i_data.byte_valid;
                    o_cmd.push_byte = i_data.data_byte;
                    if (i_data.byte_valid && full) begin
                        n_ret = i_data.message_end ? S_PAD : S_IDLE;
                        n_state = S_RND;
                        n_cnt = '0;
                    end else if (i_data.message_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.len_snap = 1'b1;
                o_cmd.push = 1'b1;
                o_cmd.push_byte = PAD_BYTE;
                n_state = full ? S_RND : S_ZERO;
                n_ret = S_ZERO;
                n_cnt = '0;
            end
            S_ZERO: begin
                if (i_sts.byte_pos == LEN_POS) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.push = 1'b1;
                    n_ret = S_ZERO;
                    n_cnt = '0;
                    if (full) begin
                        n_state = S_RND;
                    end
                end
            end
            S_LEN: begin
                o_cmd.push = 1'b1;
                o_cmd.push_byte = i_sts.len_snap[i_sts.byte_pos[2:0]*8 +: 8];
                if (full) begin
                    n_ret = S_OUT;
                    n_cnt = '0;
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.round_step = 1'b1;
                n_cnt = 6'(r_cnt + 6'd1);
                if (r_cnt == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                n_widx = '0;
                n_state = r_ret;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_widx = 2'(r_widx + 2'd1);
                    if (r_widx == 2'd3) begin
                        o_cmd.chain_init = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // load working registers from chaining value on entry to rounds
        if (n_state == S_RND && r_state != S_RND) begin
            o_cmd.round_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_cnt <= '0;
            r_widx <= '0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_cnt <= n_cnt;
            r_widx <= n_widx;
        end
    end
endmodule

[sv/md5_message_digest_core.sv]
// Top level of the MD5 message digest core
// Usage:
//   Input channel carries one request per byte: data_byte, byte_valid,
//   message_end. A request with only message_end closes the message.
//   Output channel returns four digest words a, b, c, d, word_index 0..3,
//   last_word set on the fourth.
// Sequencing:
//   A byte that does not fill a block and does not end the message leaves the core ready for the next byte.
//   The 64th byte of a block starts the 64 rounds and then the chaining add,
//   one round per cycle through the shared round unit.
//   An end request runs the padding sequencer one byte per cycle up to the
//   length field, then 8 length bytes, with one or two compressions, then
//   presents the digest words.
//   Input is stalled while padding, compressing or presenting.
// Reset:
//   Loads the standard initial chaining value and clears the bit count.
// Output stall:
//   Each digest word holds until taken; after the fourth word the core
//   reinitializes and accepts the next message.
module md5_message_digest_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  md5_pkg::t_md5_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output md5_pkg::t_md5_out o_data
);
    import md5_pkg::*;

    t_md5_cmd     cmd;
    t_md5_sts     sts;
    logic [127:0] chain;

    md5_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid, .i_stall, .o_data,
        .o_cmd(cmd), .i_sts(sts), .i_chain(chain)
    );

    md5_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .o_chain(chain)
    );
endmodule

[sv/md5_checker.sv]
// Port-level assertion checker for the MD5 digest core, with its bind
`include "assert_macros.svh"
module md5_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input md5_pkg::t_md5_in  i_data,
    input logic              o_valid,
    input logic              i_stall,
    input md5_pkg::t_md5_out o_data
);
    `CHK_IMPLY(a_no_intake_out, i_clk, i_rst_n, o_valid, o_stall, "accepting during output")
    `CHK_IMPLY(a_last_idx, i_clk, i_rst_n, o_valid,
        o_data.last_word == (o_data.word_index == 2'd3), "last_word mismatch")
    `CHK_NEXT(a_idx_adv, i_clk, i_rst_n, o_valid && !i_stall && !o_data.last_word,
        o_valid && o_data.word_index == $past(o_data.word_index) + 2'd1, "index skip")
    `CHK_NEXT(a_end_stalls, i_clk, i_rst_n,
        i_valid && !o_stall && i_data.message_end, o_stall, "end not processed")
endmodule

bind md5_message_digest_core md5_checker u_md5_checker (.*);

[bench/tb.sv]
// Testbench for md5_message_digest_core: MD5 predictor, byte driver, digest monitor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_md5_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_md5_out o_data;

    md5_message_digest_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    logic [31:0] chain_q [4];
    logic [31:0] block_q [16];
    logic [63:0] bit_count;
    logic [31:0] sine_k [64];
    int unsigned shift_tbl [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    t_md5_in  request_q [$];
    t_md5_out digest_q [$];
    int unsigned errors;
    int unsigned requests_sent;
    int unsigned words_seen;
    int unsigned messages_seen;
    bit stim_done;
    bit quiet;
    bit drain_hold;
    bit tx_taken;
    int unsigned rx_hold;
    int unsigned tx_gap;
    int unsigned rx_gap;
    int unsigned cycles;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int unsigned g, rnd;
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int i = 0; i < 64; i++) begin
            rnd = i / 16;
            case (rnd)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = f + a + sine_k[i] + block_q[g];
            a = d; d = c; c = b;
            b = b + rotl(t, shift_tbl[rnd * 4 + i % 4]);
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endfunction

    function automatic void md5_absorb(input logic [7:0] v);
        int unsigned pos;
        pos = bit_count[8:3];
        block_q[pos / 4][(pos % 4) * 8 +: 8] = v;
        bit_count += 64'd8;
        if (pos == 63) md5_compress();
    endfunction

    function automatic void md5_restart();
        chain_q[0] = IV_A; chain_q[1] = IV_B; chain_q[2] = IV_C; chain_q[3] = IV_D;
        bit_count = '0;
    endfunction

    function automatic void md5_predict(input t_md5_in r);
        logic [63:0] len;
        t_md5_out w;
        if (r.byte_valid) md5_absorb(r.data_byte);
        if (!r.message_end) return;
        len = bit_count;
        md5_absorb(PAD_BYTE);
        while (bit_count[8:3] != LEN_POS) md5_absorb(8'h00);
        for (int k = 0; k < 8; k++) md5_absorb(len[8 * k +: 8]);
        for (int k = 0; k < 4; k++) begin
            w.digest_word = chain_q[k];
            w.word_index  = 2'(k);
            w.last_word   = (k == 3);
            digest_q.push_back(w);
        end
        md5_restart();
    endfunction

    function automatic void add_req(input logic [7:0] v, input logic bv, input logic me);
        t_md5_in r;
        r.data_byte = v; r.byte_valid = bv; r.message_end = me;
        request_q.push_back(r);
    endfunction

    function automatic void add_message(input int unsigned n, input bit end_with_byte);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) add_req(8'($urandom), 1'b0, 1'b0);
            add_req(8'($urandom), 1'b1, (end_with_byte && i == n - 1));
        end
        if (!end_with_byte || n == 0) add_req(8'($urandom), 1'b0, 1'b1);
    endfunction

    // record whether the request on the bus was taken at this edge
    always @(posedge i_clk) begin
        tx_taken <= i_rst_n && i_valid && !o_stall;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !tx_taken) begin
            i_valid <= 1'b1;
        end else begin
            if (i_valid) begin
                md5_predict(i_data);
                requests_sent++;
                void'(request_q.pop_front());
            end
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (drain_hold && digest_q.size() != 0) begin
                i_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                i_valid <= 1'b1;
                i_data  <= request_q[0];
                if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 18);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and stall generator
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 11) == 0) rx_gap = $urandom_range(1, 18);
        end
    end

    always @(posedge i_clk) begin
        t_md5_out exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected digest word, expected none, actual %h/%0d/%0b",
                         $time, o_data.digest_word, o_data.word_index, o_data.last_word);
            end else begin
                exp_w = digest_q.pop_front();
                if (exp_w.last_word) messages_seen++;
                if (o_data.digest_word !== exp_w.digest_word) begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.digest_word, o_data.digest_word);
                end
                if (o_data.word_index !== exp_w.word_index) begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.word_index, o_data.word_index);
                end
                if (o_data.last_word !== exp_w.last_word) begin
                    errors++;
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             exp_w.last_word, o_data.last_word);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("md5_message_digest_core regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        sine_k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
            32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
            32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
            32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
            32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        md5_restart();
        for (int i = 0; i < 16; i++) block_q[i] = '0;
        errors = 0; requests_sent = 0; words_seen = 0; messages_seen = 0; cycles = 0;
        stim_done = 0; quiet = 0; drain_hold = 0; rx_hold = 0; tx_gap = 0; rx_gap = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, idle, extreme bytes, end carrying a byte
        add_req(8'h00, 1'b0, 1'b1);
        add_req(8'hff, 1'b0, 1'b0);
        add_req(8'h00, 1'b1, 1'b0);
        add_req(8'hff, 1'b1, 1'b0);
        add_req(8'haa, 1'b1, 1'b0);
        add_req(8'h55, 1'b1, 1'b1);
        add_req(8'h61, 1'b1, 1'b1);
        add_req(8'h00, 1'b0, 1'b1);
        add_message(3, 0);

        // hold off the receiver while bytes pile up behind a long message
        rx_hold = 300;
        add_message(70, 0);
        add_message(2, 1);
        wait (request_q.size() == 0 && digest_q.size() == 0);

        // pause the sender until the pipe drains between messages
        drain_hold = 1;
        add_message(5, 1);
        add_message(0, 0);
        wait (request_q.size() == 0 && digest_q.size() == 0);
        drain_hold = 0;

        // random messages, mostly short, a few across block boundaries
        while (requests_sent < 260) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(55, 130);
                1: n = 0;
                default: n = $urandom_range(1, 20);
            endcase
            add_message(n, $urandom_range(0, 1));
            wait (request_q.size() < 8);
        end
        wait (request_q.size() == 0);
        quiet = 1;
        add_message(56, 0);
        add_message(63, 1);
        add_message(64, 0);
        wait (request_q.size() == 0 && !i_valid);
        stim_done = 1;
        wait (digest_q.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d byte requests; checked %0d digest words over %0d messages.",
                 requests_sent, words_seen, messages_seen);
        $display("Covered empty messages, idle requests, block boundaries and stalls.");
        if (errors == 0) begin
            $display("md5_message_digest_core regression: pass");
        end else begin
            $display("md5_message_digest_core regression: fail");
        end
        $finish;
    end
endmodule
